### rtl/assert_macros.svh
// Assertion macros for the RTL files that check their own logic.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/uba_pkg.sv
// Shared types and codes for the unordered bag table.
// No dependencies; used by unordered_bag_table.
package uba_pkg;

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned POSITION_W = 6;
  localparam int unsigned ENTRIES_W  = 7;
  localparam int unsigned STATUS_W   = 2;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                  found;
    logic [POSITION_W-1:0] position;
    logic [ENTRIES_W-1:0]  entries;
    logic [STATUS_W-1:0]   status;
  } rsp_t;

endpackage

### rtl/unordered_bag_table.sv
// Unordered bag table: bounded multiset of signed 32-bit values in one RAM.
// Depends on uba_pkg, uba_ram and assert_macros.svh.
//
//   channel | dir | handshake           | beat
//   --------+-----+---------------------+--------------------------------------
//   req     | in  | req_valid/req_stall | opcode, value
//   rsp     | out | rsp_valid/rsp_stall | found, position, entries, status
//
// Insert, a rejected insert and the unused opcode go from accept straight to the result.
// Remove and query scan the store with one compare per cycle through the
// single RAM read port; a successful remove then copies the last entry
// over the matched slot through the fetch and copy states.
// Reset clears the entry count and the control state; the store needs no clearing pass.
// A held response stalls the sequencer only when the next response is ready.

`include "assert_macros.svh"

module unordered_bag_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  uba_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output uba_pkg::rsp_t rsp
);

  localparam int unsigned AW = $clog2(CAPACITY);      // store address bits
  localparam int unsigned CW = $clog2(CAPACITY + 1);  // count bits (holds CAPACITY)

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_FETCH  = 5'b00100,
    S_COPY   = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t                             state;
  logic [uba_pkg::OPCODE_W-1:0]       op;
  logic [uba_pkg::VALUE_W-1:0]        key;
  logic [CW-1:0]                      count;
  logic [CW-1:0]                      scan_idx;   // next slot to read
  logic                               cmp_vld;    // read data of cmp_idx is on rd_data
  logic [CW-1:0]                      cmp_idx;
  logic [CW-1:0]                      slot;       // matched or written slot
  logic                               res_found;
  logic [uba_pkg::STATUS_W-1:0]       res_status;

  logic                               req_accept;
  logic                               full;
  logic                               ins_ok;
  logic                               issue_ok;
  logic                               hit;
  logic                               last;
  logic [CW-1:0]                      last_idx;
  logic                               copy_phase;
  logic                               found_remove;

  logic                               wr_en;
  logic [AW-1:0]                      wr_addr;
  logic [uba_pkg::VALUE_W-1:0]        wr_data;
  logic                               rd_en;
  logic [AW-1:0]                      rd_addr;
  logic [uba_pkg::VALUE_W-1:0]        rd_data;

  // Take a new request only when the sequencer is parked.
  assign req_stall  = (state != S_IDLE);
  assign req_accept = req_valid && !req_stall;

  assign full     = (count >= CW'(CAPACITY));
  assign ins_ok   = req_accept && (req.opcode == uba_pkg::OP_INSERT) && !full;
  assign last_idx = count - CW'(1);
  assign issue_ok = (scan_idx < count);

  // The shared compare: one stored entry against the key per cycle.
  assign hit  = cmp_vld && (rd_data == key);
  assign last = cmp_vld && (cmp_idx == last_idx);

  assign copy_phase   = (state == S_FETCH) || (state == S_COPY);
  assign found_remove = res_found && (op == uba_pkg::OP_REMOVE);

  // Store port control: insert writes at the tail, remove copies the tail
  // entry over the matched slot.
  always_comb begin
    wr_en   = ins_ok || (state == S_COPY);
    wr_addr = (state == S_COPY) ? slot[AW-1:0] : count[AW-1:0];
    wr_data = (state == S_COPY) ? rd_data : req.value;
    rd_en   = ((state == S_SCAN) && issue_ok) || (state == S_FETCH);
    rd_addr = (state == S_FETCH) ? last_idx[AW-1:0] : scan_idx[AW-1:0];
  end

  uba_ram #(
    .WIDTH (uba_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer: accept, scan, optional tail copy, then post the response.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cmp_vld   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // Drop the response beat once it is taken, unless a new one replaces it.
      if (rsp_valid && !rsp_stall && (state != S_RESULT)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          cmp_vld <= 1'b0;
          if (req_accept) begin
            op        <= req.opcode;
            key       <= req.value;
            scan_idx  <= '0;
            res_found <= 1'b0;
            if (req.opcode == uba_pkg::OP_INSERT) begin
              if (full) begin
                slot       <= '0;
                res_status <= uba_pkg::ST_FULL;
              end else begin
                slot       <= count;
                count      <= count + CW'(1);
                res_status <= uba_pkg::ST_DONE;
              end
              state <= S_RESULT;
            end else if ((req.opcode == uba_pkg::OP_REMOVE) ||
                         (req.opcode == uba_pkg::OP_QUERY)) begin
              slot <= '0;
              if (count == '0) begin
                res_status <= uba_pkg::ST_ABSENT;
                state      <= S_RESULT;
              end else begin
                res_status <= uba_pkg::ST_DONE;
                state      <= S_SCAN;
              end
            end else begin
              slot       <= '0;
              res_status <= uba_pkg::ST_DONE;
              state      <= S_RESULT;
            end
          end
        end

        S_SCAN: begin
          // Issue one read per cycle; compare the previous read.
          cmp_vld <= issue_ok && !(hit || last);
          cmp_idx <= scan_idx;
          if (issue_ok) begin
            scan_idx <= scan_idx + CW'(1);
          end
          if (hit) begin
            res_found <= 1'b1;
            slot      <= cmp_idx;
            state     <= (op == uba_pkg::OP_REMOVE) ? S_FETCH : S_RESULT;
          end else if (last) begin
            res_status <= uba_pkg::ST_ABSENT;
            state      <= S_RESULT;
          end
        end

        S_FETCH: begin
          // Tail entry read is in flight.
          state <= S_COPY;
        end

        S_COPY: begin
          count <= count - CW'(1);
          state <= S_RESULT;
        end

        S_RESULT: begin
          // Hold until the output register is free.
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid    <= 1'b1;
            rsp.found    <= res_found;
            rsp.position <= uba_pkg::POSITION_W'(slot);
            rsp.entries  <= uba_pkg::ENTRIES_W'(count);
            rsp.status   <= res_status;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on the sequencer and the entry count.
  `ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= CW'(CAPACITY), "count above capacity")
  `ASSERT_NEXT(a_insert_grow, clk, rst, ins_ok, count == $past(count) + CW'(1), "insert kept count")
  `ASSERT_NEXT(a_copy_shrink, clk, rst, state == S_COPY, count == $past(count) - CW'(1), "copy kept count")
  `ASSERT_NEXT(a_copy_result, clk, rst, state == S_COPY, state == S_RESULT, "copy not followed by result")
  `ASSERT_IMPLY(a_copy_remove, clk, rst, copy_phase, found_remove, "tail copy outside a found remove")

endmodule

### rtl/uba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used by unordered_bag_table for the element store.
module uba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
